### src/assert_macros.svh
// Assertion macros used by the one checker file of this project, jsu_checker.sv.
// Depends on nothing; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent on one edge implies the consequent on the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent on one edge implies the consequent on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/jsu_pkg.sv
// Shared types, codes and helper functions of the JSON string unescaper.
// Depends on nothing; used by every module of the block.
`default_nettype none

package jsu_pkg;

  // Decoder phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_STR  = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_CTRL     = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_HEX      = 3'd4;
  localparam logic [2:0] ERR_RANGE    = 3'd5;
  localparam logic [2:0] ERR_UNTERM   = 3'd6;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CTRL  = 8'h20;

  // Decoder state: upper code bits collapse into one overflow flag
  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] hex_cnt;
    logic [7:0] acc;
    logic       big;
  } dec_state_t;

  // One result of the decoder
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
  } result_t;

  // Hex digit value; bit 4 set marks a byte that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = 5'(c[3:0] + 4'd9);
    return v;
  endfunction

endpackage

`default_nettype wire

### src/json_string_unescape.sv
// JSON string unescaper: takes one raw byte per transaction and gives at most one
// result per byte (a decoded byte, the end of the string, or an error code). A byte
// can be accepted every cycle while the result register is free or drains; it passes
// an input register, then one decode step that updates the phase state, then the
// result register, which takes the result once it is free and holds it until taken.
// The rate is one byte per cycle under the same condition; the phase and \u code
// register update once per consumed byte. No clearing pass after reset.
// Depends on jsu_pkg, jsu_decode and jsu_out_stage.
`default_nettype none

module json_string_unescape import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [2:0] error_code_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       advance;
  logic       consume;
  dec_state_t st_q, st_d;
  result_t    res;

  // Input stage moves forward when the result register can take its result
  assign consume    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Capture an accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= end_of_input_i;
    end
  end

  jsu_decode u_decode (
    .st_i   (st_q),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // Advance the decoder state once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, hex_cnt: 2'd0, acc: 8'd0, big: 1'b0};
    end else if (consume) begin
      st_q <= st_d;
    end
  end

  jsu_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_valid_q),
    .res_i        (res),
    .free_o       (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .error_code_o (error_code_o)
  );

endmodule

`default_nettype wire

### src/jsu_decode.sv
// Combinational decode step: current state and one byte give next state and result.
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode import jsu_pkg::*; (
  input  dec_state_t st_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output dec_state_t st_o,
  output result_t    res_o
);

  dec_state_t idle_st;
  logic [4:0] hv;
  logic [7:0] acc_n;
  logic       big_n;
  logic       esc_ok;
  logic [7:0] esc_val;

  assign idle_st = '{phase: PH_IDLE, hex_cnt: 2'd0, acc: 8'd0, big: 1'b0};
  assign hv      = hex_value(byte_i);
  assign acc_n   = {st_i.acc[3:0], hv[3:0]};
  assign big_n   = st_i.big | (st_i.acc[7:4] != 4'd0);

  // Map escape letters to their byte
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = byte_i;
    unique case (byte_i)
      CH_QUOTE, CH_BSL, CH_SLASH: esc_val = byte_i;
      8'h62:   esc_val = 8'h08;
      8'h66:   esc_val = 8'h0C;
      8'h6E:   esc_val = 8'h0A;
      8'h72:   esc_val = 8'h0D;
      8'h74:   esc_val = 8'h09;
      default: esc_ok  = 1'b0;
    endcase
  end

  // Phase machine of one step
  always_comb begin
    st_o  = st_i;
    res_o = '{valid: 1'b0, data: 8'd0, kind: KIND_BYTE, err: ERR_NONE};
    unique case (st_i.phase)
      PH_IDLE: begin
        if (byte_i != CH_QUOTE) begin
          res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_NO_QUOTE};
        end else if (last_i) begin
          res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_UNTERM};
        end else begin
          st_o.phase = PH_STR;
        end
      end
      PH_STR: begin
        if (byte_i == CH_QUOTE) begin
          st_o  = idle_st;
          res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_END, err: ERR_NONE};
        end else if (byte_i == CH_BSL) begin
          if (last_i) begin
            st_o  = idle_st;
            res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_UNTERM};
          end else begin
            st_o.phase = PH_ESC;
          end
        end else if (byte_i < CH_CTRL) begin
          st_o  = idle_st;
          res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_CTRL};
        end else if (last_i) begin
          st_o  = idle_st;
          res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_UNTERM};
        end else begin
          res_o = '{valid: 1'b1, data: byte_i, kind: KIND_BYTE, err: ERR_NONE};
        end
      end
      PH_ESC: begin
        if (byte_i == 8'h75) begin
          if (last_i) begin
            st_o  = idle_st;
            res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_UNTERM};
          end else begin
            st_o = '{phase: PH_HEX, hex_cnt: 2'd0, acc: 8'd0, big: 1'b0};
          end
        end else if (!esc_ok) begin
          st_o  = idle_st;
          res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_ESCAPE};
        end else if (last_i) begin
          st_o  = idle_st;
          res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_UNTERM};
        end else begin
          st_o.phase = PH_STR;
          res_o = '{valid: 1'b1, data: esc_val, kind: KIND_BYTE, err: ERR_NONE};
        end
      end
      PH_HEX: begin
        if (hv[4]) begin
          st_o  = idle_st;
          res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_HEX};
        end else if (st_i.hex_cnt == 2'd3) begin
          // Fourth digit closes the code
          if (big_n) begin
            st_o  = idle_st;
            res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_RANGE};
          end else if (last_i) begin
            st_o  = idle_st;
            res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_UNTERM};
          end else begin
            st_o = '{phase: PH_STR, hex_cnt: 2'd0, acc: 8'd0, big: 1'b0};
            res_o = '{valid: 1'b1, data: acc_n, kind: KIND_BYTE, err: ERR_NONE};
          end
        end else if (last_i) begin
          st_o  = idle_st;
          res_o = '{valid: 1'b1, data: 8'd0, kind: KIND_ERR, err: ERR_UNTERM};
        end else begin
          st_o.hex_cnt = st_i.hex_cnt + 2'd1;
          st_o.acc     = acc_n;
          st_o.big     = big_n;
        end
      end
      default: st_o = idle_st;
    endcase
  end

endmodule

`default_nettype wire

### src/jsu_out_stage.sv
// Result register of the unescaper with its valid/ready handshake.
// Depends on jsu_pkg.
`default_nettype none

module jsu_out_stage import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    res_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [2:0] error_code_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic [1:0] kind_q;
  logic [2:0] err_q;

  // Register may take a new result when empty or being drained
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = free_o ? (load_i && res_i.valid) : valid_q;

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload when a result enters
  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_i.valid) begin
      data_q <= res_i.data;
      kind_q <= res_i.kind;
      err_q  <= res_i.err;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = data_q;
  assign kind_o       = kind_q;
  assign error_code_o = err_q;

endmodule

`default_nettype wire

### src/jsu_checker.sv
// Port-level checks of the JSON string unescaper, bound to the top level.
// Depends on assert_macros.svh and jsu_pkg.
`default_nettype none

`include "assert_macros.svh"

module jsu_checker import jsu_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] kind_o,
  input logic [2:0] error_code_o
);

  logic        plain_ok;
  logic        err_ok;
  logic        out_stall;
  logic [12:0] out_payload;

  // Field rules of a delivered result
  assign plain_ok = (error_code_o == ERR_NONE) && (kind_o == KIND_BYTE || out_byte_o == 8'd0);
  assign err_ok   = (error_code_o != ERR_NONE) && (error_code_o != 3'd7) && (out_byte_o == 8'd0);

  // Result waiting on the channel
  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_payload = {out_byte_o, kind_o, error_code_o};

  // Three result kinds only; only error results carry an error code
  `ASSERT_IMPLIES(a_kind_legal, clk_i, rst_ni, out_valid_o, kind_o != 2'd3)
  `ASSERT_IMPLIES(a_err_match, clk_i, rst_ni, out_valid_o && kind_o != KIND_ERR, plain_ok)
  `ASSERT_IMPLIES(a_err_code, clk_i, rst_ni, out_valid_o && kind_o == KIND_ERR, err_ok)
  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_payload))
  // Input side is never blocked while the result register drains
  `ASSERT_IMPLIES(a_in_ready, clk_i, rst_ni, out_ready_i, in_ready_o)

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .kind_o         (kind_o),
  .error_code_o   (error_code_o)
);

`default_nettype wire

### tb/json_unescape_checker.sv
// Scoreboard for the JSON string unescaper: predicts each result from the accepted input
// bytes and compares it with what the block delivers on its result channel.
// Depends on jsu_pkg for the phase, kind, error and character codes.
`default_nettype none

module json_unescape_checker import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  input  logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_o,
  input  logic [1:0] kind_o,
  input  logic [2:0] error_code_o,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o,
  output int         closed_o,
  output int         errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
  } decoded_t;

  // Predicted decoder state
  logic [1:0]  dec_phase;
  logic [2:0]  hex_seen;
  logic [15:0] code_acc;

  decoded_t expected_results [$];
  decoded_t want;
  decoded_t predicted;
  bit       produced;
  int       mismatches;
  int       checked;
  int       closed;
  int       errors;

  // Value of a hex digit; bit 4 marks a byte that is no hex digit
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'h10;
  endfunction

  // End the string with an error and return to idle
  function automatic decoded_t drop_string(input logic [2:0] code);
    decoded_t r;
    dec_phase = PH_IDLE;
    hex_seen  = '0;
    code_acc  = '0;
    r      = '0;
    r.kind = KIND_ERR;
    r.err  = code;
    return r;
  endfunction

  // A decoded byte, unless the text ends here without a closing quote
  function automatic decoded_t pass_byte(input logic [7:0] b, input logic last);
    decoded_t r;
    if (last) return drop_string(ERR_UNTERM);
    r      = '0;
    r.data = b;
    r.kind = KIND_BYTE;
    return r;
  endfunction

  // Advance the predicted decoder by one byte
  task automatic decode_byte(input logic [7:0] c, input logic last,
                             output bit has_result, output decoded_t r);
    logic [4:0] v;
    logic [7:0] esc;
    bit         esc_ok;
    has_result = 1'b1;
    r          = '0;
    esc        = '0;
    esc_ok     = 1'b1;
    case (dec_phase)
      PH_IDLE: begin
        if (c != CH_QUOTE) r = drop_string(ERR_NO_QUOTE);
        else if (last) r = drop_string(ERR_UNTERM);
        else begin
          dec_phase  = PH_STR;
          has_result = 1'b0;
        end
      end
      PH_STR: begin
        if (c == CH_QUOTE) begin
          dec_phase = PH_IDLE;
          r.kind    = KIND_END;
        end else if (c == CH_BSL) begin
          if (last) r = drop_string(ERR_UNTERM);
          else begin
            dec_phase  = PH_ESC;
            has_result = 1'b0;
          end
        end else if (c < CH_CTRL) begin
          r = drop_string(ERR_CTRL);
        end else begin
          r = pass_byte(c, last);
        end
      end
      PH_ESC: begin
        case (c)
          CH_QUOTE, CH_BSL, CH_SLASH: esc = c;
          "b": esc = 8'h08;
          "f": esc = 8'h0C;
          "n": esc = 8'h0A;
          "r": esc = 8'h0D;
          "t": esc = 8'h09;
          "u": begin
            esc_ok = 1'b0;
            if (last) r = drop_string(ERR_UNTERM);
            else begin
              dec_phase  = PH_HEX;
              hex_seen   = '0;
              code_acc   = '0;
              has_result = 1'b0;
            end
          end
          default: begin
            esc_ok = 1'b0;
            r      = drop_string(ERR_ESCAPE);
          end
        endcase
        if (esc_ok) begin
          dec_phase = PH_STR;
          r         = pass_byte(esc, last);
        end
      end
      default: begin
        v = digit_value(c);
        if (v[4]) begin
          r = drop_string(ERR_HEX);
        end else begin
          code_acc = {code_acc[11:0], v[3:0]};
          hex_seen = hex_seen + 3'd1;
          if (hex_seen >= 3'd4) begin
            if (code_acc > 16'h00FF) r = drop_string(ERR_RANGE);
            else begin
              esc       = code_acc[7:0];
              dec_phase = PH_STR;
              hex_seen  = '0;
              code_acc  = '0;
              r         = pass_byte(esc, last);
            end
          end else if (last) begin
            r = drop_string(ERR_UNTERM);
          end else begin
            has_result = 1'b0;
          end
        end
      end
    endcase
  endtask

  // Compare delivered results first, then predict from the accepted byte
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dec_phase  = PH_IDLE;
      hex_seen   = '0;
      code_acc   = '0;
      mismatches = 0;
      checked    = 0;
      closed     = 0;
      errors     = 0;
      expected_results.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_byte %02h kind %0d error_code %0d",
                 out_byte_o, kind_o, error_code_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.kind == KIND_END) closed++;
          if (want.kind == KIND_ERR) errors++;
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte_o);
            mismatches++;
          end
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind_o);
            mismatches++;
          end
          if (error_code_o !== want.err) begin
            $error("error_code: expected %0d, actual %0d", want.err, error_code_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        decode_byte(in_byte_i, end_of_input_i, produced, predicted);
        if (produced) expected_results.insert(expected_results.size(), predicted);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results.size();
    checked_o    <= checked;
    closed_o     <= closed;
    errors_o     <= errors;
  end

endmodule

`default_nettype wire

### tb/testbench.sv
// Top of the JSON string unescaper testbench: clock, reset, byte stimulus and verdict.
// Depends on jsu_pkg, json_string_unescape and json_unescape_checker.
`default_nettype none

module testbench import jsu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1900;
  localparam int STALL_LIMIT  = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       end_of_input_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic [2:0] error_code_o;

  int fail_count;
  int pending;
  int checked;
  int closed;
  int errors;

  int sent_count;
  int stall_cycles = 0;
  bit no_gaps;

  logic [8:0] directed_bytes [$];
  string      esc_letters;

  json_string_unescape DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .kind_o         (kind_o),
    .error_code_o   (error_code_o)
  );

  json_unescape_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .kind_o         (kind_o),
    .error_code_o   (error_code_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .closed_o       (closed),
    .errors_o       (errors)
  );

  always #4 clk_i = ~clk_i;

  // Stall the result channel at random, except during the gap-free stretch
  always @(negedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= 31);
  end

  // End the run when neither channel moves a transaction for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Offer one byte after a random gap and hold it until accepted; call at a falling edge
  task automatic send_item(input logic [7:0] b, input logic last);
    no_gaps = (sent_count >= 800) && (sent_count < 1100);
    while (!no_gaps && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_byte_i      <= b;
    end_of_input_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Hex digit character of a nibble, letters in random case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    if ($urandom_range(1) == 0) return 8'("a") + 8'(n) - 8'd10;
    return 8'("A") + 8'(n) - 8'd10;
  endfunction

  initial begin
    logic [7:0]  ch;
    logic [15:0] code;
    int          pick;
    int          tok;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    end_of_input_i = 1'b0;
    sent_count     = 0;
    no_gaps        = 1'b0;
    esc_letters    = "\"\\/bfnrt";

    // Bit 8 marks the last byte of the text
    directed_bytes = '{
      {1'b0, 8'h00}, {1'b1, 8'hFF},                  // no opening quote
      {1'b1, CH_QUOTE},                              // opening quote that ends the text
      {1'b0, CH_QUOTE}, {1'b1, 8'h41},               // plain byte that ends the text
      {1'b0, CH_QUOTE}, {1'b0, 8'h20}, {1'b0, 8'hFF},
      {1'b0, CH_BSL}, {1'b0, 8'h6E},                 // \n
      {1'b0, CH_BSL}, {1'b0, 8'h75}, {1'b0, 8'h30},  // \u0000
      {1'b0, 8'h30}, {1'b0, 8'h30}, {1'b0, 8'h30},
      {1'b1, CH_QUOTE},                              // closing quote that ends the text
      {1'b0, CH_QUOTE}, {1'b0, 8'h1F},               // control byte
      {1'b0, CH_QUOTE}, {1'b0, CH_BSL}, {1'b0, 8'h0A}, // control byte after backslash
      {1'b0, CH_QUOTE}, {1'b0, CH_BSL}, {1'b0, 8'h75}, {1'b0, 8'h47} // bad hex digit
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_bytes[i]) send_item(directed_bytes[i][7:0], directed_bytes[i][8]);

    // Mostly well-formed strings with random content, some noise and truncated strings
    while (sent_count < directed_bytes.size() + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(3, 1)) send_item(8'($urandom()), $urandom_range(7) == 0);
      end else begin
        send_item(CH_QUOTE, $urandom_range(49) == 0);
        repeat ($urandom_range(10, 0)) begin
          tok = $urandom_range(99);
          if (tok < 55) begin
            do ch = 8'($urandom_range(8'hFF, 8'h20));
            while (ch == CH_QUOTE || ch == CH_BSL);
            send_item(ch, $urandom_range(149) == 0);
          end else if (tok < 80) begin
            send_item(CH_BSL, $urandom_range(149) == 0);
            send_item(esc_letters[$urandom_range(7)], $urandom_range(149) == 0);
          end else if (tok < 95) begin
            if ($urandom_range(4) == 0) code = 16'($urandom());
            else code = {8'h00, 8'($urandom())};
            send_item(CH_BSL, 1'b0);
            send_item("u", $urandom_range(149) == 0);
            for (int k = 3; k >= 0; k--) begin
              send_item(hex_char(code[k*4 +: 4]), $urandom_range(99) == 0);
            end
          end else begin
            send_item(8'($urandom()), $urandom_range(9) == 0);
          end
        end
        if (pick < 88) send_item(CH_QUOTE, $urandom_range(5) == 0);
        else send_item(8'($urandom()), 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow for the pipeline latency
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("summary: %0d input bytes, %0d results compared", sent_count, checked);
    $display("summary: %0d strings closed, %0d error results", closed, errors);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
